>>> hw/rtl/lpps_pkg.sv
// Shared constants, codes and types of the LED PWM pattern sequencer.
package lpps_pkg;

   localparam int LED_COUNT  = 8;
   localparam int MAX_STEPS  = 16;
   localparam int RSP_DEPTH  = 2;

   localparam int STEP_W     = $clog2(MAX_STEPS);
   localparam int LED_W      = 3;
   localparam int DUTY_W     = 7;
   localparam int TICK_W     = 7;
   localparam int DWELL_W    = 6;
   localparam int STEPS_W    = 5;
   localparam int PINS_W     = LED_COUNT;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam logic [STEPS_W-1:0] STEPS_RESET  = STEPS_W'(16);
   localparam logic [TICK_W-1:0]  PERIOD_RESET = TICK_W'(100);
   localparam logic [DWELL_W-1:0] DWELL_RESET  = DWELL_W'(50);
   localparam logic [STEP_W-1:0]  SMUDGE_SKIP  = STEP_W'(2);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SMUDGED = 2'd0,
      CSR_STEPS   = 2'd1,
      CSR_PERIOD  = 2'd2,
      CSR_DWELL   = 2'd3
   } csr_index_type;

   typedef enum logic {
      KIND_TICK  = 1'b0,
      KIND_WRITE = 1'b1
   } kind_type;

   typedef logic [LED_COUNT-1:0][DUTY_W-1:0] duty_row_type;

   typedef struct packed {
      logic              en;
      logic [STEP_W-1:0] step;
      logic [LED_W-1:0]  led;
      logic [DUTY_W-1:0] duty;
   } store_wr_type;

   typedef struct packed {
      logic               smudged;
      logic [STEPS_W-1:0] steps;
      logic [TICK_W-1:0]  period;
      logic [DWELL_W-1:0] dwell;
   } cfg_type;

   typedef struct packed {
      logic [PINS_W-1:0] led_pins;
      logic [STEP_W-1:0] step_index;
   } result_type;

endpackage

>>> hw/rtl/lpps_if.sv
// Request and response channel interfaces of the LED PWM pattern sequencer.
interface lpps_req_if;
   import lpps_pkg::*;

   logic              valid;
   logic              ready;
   logic              kind;
   logic [STEP_W-1:0] entry_step;
   logic [LED_W-1:0]  entry_led;
   logic [DUTY_W-1:0] entry_duty;

   modport source (output valid, kind, entry_step, entry_led, entry_duty, input ready);
   modport sink   (input valid, kind, entry_step, entry_led, entry_duty, output ready);
endinterface

interface lpps_rsp_if;
   import lpps_pkg::*;

   logic              valid;
   logic              ready;
   logic [PINS_W-1:0] led_pins;
   logic [STEP_W-1:0] step_index;

   modport source (output valid, led_pins, step_index, input ready);
   modport sink   (input valid, led_pins, step_index, output ready);
endinterface

>>> hw/rtl/lpps_store.sv
// Pattern store: one row of duties per step, written one LED at a time.
module lpps_store (
   input  logic                         clock,
   input  logic                         reset,
   input  lpps_pkg::store_wr_type       wr_i,
   input  logic [lpps_pkg::STEP_W-1:0]  rd_step_i,
   output lpps_pkg::duty_row_type       row_o
);
   import lpps_pkg::*;

   duty_row_type rows_ff [MAX_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < MAX_STEPS; s++) begin
            rows_ff[s] <= '0;
         end
      end else if (wr_i.en) begin
         rows_ff[wr_i.step][wr_i.led] <= wr_i.duty;
      end
   end

   assign row_o = rows_ff[rd_step_i];

endmodule

>>> hw/rtl/lpps_core.sv
// Tick engine: pin levels, tick and dwell counters, step sequencing.
module lpps_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         tick_i,
   input  lpps_pkg::cfg_type            cfg_i,
   input  lpps_pkg::duty_row_type       row_i,
   output logic [lpps_pkg::STEP_W-1:0]  rd_step_o,
   output lpps_pkg::result_type         result_o
);
   import lpps_pkg::*;

   logic [TICK_W-1:0]  tick_ff,    tick_in;
   logic [DWELL_W-1:0] dwell_ff,   dwell_in;
   logic [STEP_W-1:0]  step_ff,    step_in;
   logic               wrapped_ff, wrapped_in;
   logic [PINS_W-1:0]  pins_ff,    pins_in;

   logic [STEP_W-1:0]  cur_step;
   logic [TICK_W-1:0]  tick_nxt;
   logic [STEPS_W-1:0] eff_steps;
   logic [STEP_W-1:0]  last_step;
   logic [PINS_W-1:0]  pins_tick;

   // Smudged skip: after the first wrap, steps zero and one are jumped over.
   always_comb begin
      if (cfg_i.smudged && wrapped_ff && (step_ff < SMUDGE_SKIP)) begin
         cur_step = step_ff + SMUDGE_SKIP;
      end else begin
         cur_step = step_ff;
      end
   end

   assign rd_step_o = cur_step;

   // Pin p follows the duty of LED LED_COUNT-1-p.
   always_comb begin
      pins_tick = pins_ff;
      for (int p = 0; p < LED_COUNT; p++) begin
         if (tick_ff == '0 && row_i[LED_COUNT-1-p] != '0) begin
            pins_tick[p] = 1'b1;
         end else if (tick_ff == row_i[LED_COUNT-1-p]) begin
            pins_tick[p] = 1'b0;
         end
      end
   end

   always_comb begin
      if (cfg_i.steps == '0) begin
         eff_steps = STEPS_W'(1);
      end else if (cfg_i.steps > STEPS_W'(MAX_STEPS)) begin
         eff_steps = STEPS_W'(MAX_STEPS);
      end else begin
         eff_steps = cfg_i.steps;
      end
      last_step = STEP_W'(eff_steps - STEPS_W'(1));
   end

   assign tick_nxt = tick_ff + TICK_W'(1);

   always_comb begin
      tick_in    = tick_ff;
      dwell_in   = dwell_ff;
      step_in    = step_ff;
      wrapped_in = wrapped_ff;
      pins_in    = pins_ff;
      if (tick_i) begin
         pins_in = pins_tick;
         step_in = cur_step;
         tick_in = tick_nxt;
         if (tick_nxt >= cfg_i.period) begin
            tick_in = '0;
            if (dwell_ff >= cfg_i.dwell) begin
               dwell_in = '0;
               // Wrap also covers a step pushed past the end by the skip.
               if (cur_step >= last_step) begin
                  step_in    = '0;
                  wrapped_in = 1'b1;
               end else begin
                  step_in = cur_step + STEP_W'(1);
               end
            end else begin
               dwell_in = dwell_ff + DWELL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff    <= '0;
         dwell_ff   <= '0;
         step_ff    <= '0;
         wrapped_ff <= 1'b0;
         pins_ff    <= '0;
      end else begin
         tick_ff    <= tick_in;
         dwell_ff   <= dwell_in;
         step_ff    <= step_in;
         wrapped_ff <= wrapped_in;
         pins_ff    <= pins_in;
      end
   end

   assign result_o.led_pins   = pins_in;
   assign result_o.step_index = step_in;

   a_write_holds_step: assert property (@(posedge clock) disable iff (reset)
      !tick_i |=> $stable(step_ff))
      else $error("step moved without a tick");

   a_write_holds_pins: assert property (@(posedge clock) disable iff (reset)
      !tick_i |=> $stable(pins_ff))
      else $error("pins moved without a tick");

   a_wrap_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(wrapped_ff))
      else $error("wrap mark cleared outside reset");

endmodule

>>> hw/rtl/lpps_rsp_buf.sv
// Two-entry result buffer between the tick engine and the response channel.
module lpps_rsp_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_i,
   input  lpps_pkg::result_type  data_i,
   input  logic                  pop_i,
   output logic                  valid_o,
   output logic                  not_full_o,
   output lpps_pkg::result_type  data_o
);
   import lpps_pkg::*;

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   result_type         buf_ff [RSP_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
      if (ptr == PTR_W'(RSP_DEPTH - 1)) begin
         return '0;
      end
      return ptr + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push_i ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop_i  ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_i && !pop_i) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_i && !push_i) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         buf_ff[wr_ptr_ff] <= data_i;
      end
   end

   assign valid_o    = count_ff != '0;
   assign not_full_o = count_ff != CNT_W'(RSP_DEPTH);
   assign data_o     = buf_ff[rd_ptr_ff];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RSP_DEPTH))
      else $error("result buffer count out of range");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'(RSP_DEPTH) |-> !push_i)
      else $error("push into a full result buffer");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop_i |-> count_ff != '0)
      else $error("pop from an empty result buffer");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push_i && !pop_i |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("result buffer lost a transfer");

endmodule

>>> hw/rtl/led_pwm_pattern_sequencer.sv
// Top level of the eight-channel LED PWM pattern sequencer.
// Takes one request per clock and returns one response per request, in order.
// A tick request updates the pins, counters and step in the cycle it transfers,
// from a row of the pattern store read in the same cycle; a write request stores
// one duty and echoes the current pins and step. Responses wait in a two-entry
// buffer, so req_chan.ready stays high under a continuous flow and drops only
// while two responses are held unread. The pattern store clears at reset with
// no clearing pass; requests are taken from the first cycle after reset.
module led_pwm_pattern_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [lpps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lpps_pkg::CSR_DATA_W-1:0] csr_wr_data,
   lpps_req_if.sink                        req_chan,
   lpps_rsp_if.source                      rsp_chan
);
   import lpps_pkg::*;

   cfg_type      cfg_ff;
   store_wr_type store_wr;
   duty_row_type row;
   logic [STEP_W-1:0] rd_step;
   result_type   result;
   result_type   rsp_data;
   logic         req_xfer;
   logic         tick;
   logic         not_full;
   logic         rsp_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.smudged <= 1'b0;
         cfg_ff.steps   <= STEPS_RESET;
         cfg_ff.period  <= PERIOD_RESET;
         cfg_ff.dwell   <= DWELL_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_SMUDGED: cfg_ff.smudged <= csr_wr_data[0];
            CSR_STEPS:   cfg_ff.steps   <= csr_wr_data[STEPS_W-1:0];
            CSR_PERIOD:  cfg_ff.period  <= csr_wr_data[TICK_W-1:0];
            CSR_DWELL:   cfg_ff.dwell   <= csr_wr_data[DWELL_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_chan.ready = not_full;
   assign req_xfer       = req_chan.valid && not_full;
   assign tick           = req_xfer && (kind_type'(req_chan.kind) == KIND_TICK);

   assign store_wr.en   = req_xfer && (kind_type'(req_chan.kind) == KIND_WRITE);
   assign store_wr.step = req_chan.entry_step;
   assign store_wr.led  = req_chan.entry_led;
   assign store_wr.duty = req_chan.entry_duty;

   lpps_store u_store (
      .clock     (clock),
      .reset     (reset),
      .wr_i      (store_wr),
      .rd_step_i (rd_step),
      .row_o     (row)
   );

   lpps_core u_core (
      .clock     (clock),
      .reset     (reset),
      .tick_i    (tick),
      .cfg_i     (cfg_ff),
      .row_i     (row),
      .rd_step_o (rd_step),
      .result_o  (result)
   );

   lpps_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push_i     (req_xfer),
      .data_i     (result),
      .pop_i      (rsp_valid && rsp_chan.ready),
      .valid_o    (rsp_valid),
      .not_full_o (not_full),
      .data_o     (rsp_data)
   );

   assign rsp_chan.valid      = rsp_valid;
   assign rsp_chan.led_pins   = rsp_data.led_pins;
   assign rsp_chan.step_index = rsp_data.step_index;

endmodule
